/* design/dq_pkg.sv */
// dq_pkg: shared types and codes for the double-ended queue.
// Holds the action codes and the input/result payload structs.
// No dependencies.
package dq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 11;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_POP_BACK   = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [DataW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] popped_value;
    logic                    pop_valid;
    logic [CountW-1:0]       element_count;
    logic                    is_empty;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] back_value;
    logic                    push_dropped;
  } out_t;

endpackage

/* design/double_ended_queue.sv */
// double_ended_queue: top level of the deque, a circular buffer in dq_ram.
// Depends on dq_pkg and dq_ram.
//
// Every accepted transfer yields one result transfer. Push, query and a pop that
// leaves zero or one element are served from registers alone; a pop that
// leaves two or more elements also passes through ST_FETCH, since the new end
// element is fetched from the RAM, whose read port is registered. The current
// front and back values live in registers, so each step needs at most one RAM
// access. A new item is taken when no fetch is pending and the result register
// is empty or is drained in the same cycle. A push into a full queue is dropped
// and flagged; a pop from an empty queue returns pop_valid low and a zero value.
module double_ended_queue #(
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dq_pkg::in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output dq_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  typedef enum logic {ST_IDLE, ST_FETCH} state_e;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - AW'(1);
  endfunction

  state_e                 state_q, state_d;
  logic [AW-1:0]          head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]          count_q, count_d;
  logic [VALUE_WIDTH-1:0] front_q, front_d, back_q, back_d;
  logic                   fetch_front_q, fetch_front_d;
  logic                   out_valid_q, out_valid_d;
  dq_pkg::out_t           out_q, out_d, res;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata, push_val;
  logic                   in_xfer;

  assign push_val   = VALUE_WIDTH'($unsigned(in_data_i.push_value));
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  dq_ram #(
    .Width(VALUE_WIDTH),
    .Depth(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    front_d       = front_q;
    back_d        = back_q;
    fetch_front_d = fetch_front_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = tail_q;
    ram_raddr     = head_q;
    ram_wdata     = push_val;
    res           = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.action)
            dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
              if (count_q == FullCnt) begin
                res.push_dropped = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (in_data_i.action == dq_pkg::ACT_PUSH_FRONT) begin
                  head_d    = idx_dec(head_q);
                  ram_waddr = idx_dec(head_q);
                  front_d   = push_val;
                  if (count_q == '0) back_d = push_val;
                end else begin
                  tail_d = idx_inc(tail_q);
                  back_d = push_val;
                  if (count_q == '0) front_d = push_val;
                end
              end
            end
            dq_pkg::ACT_POP_FRONT: begin
              if (count_q != '0) begin
                res.pop_valid    = 1'b1;
                res.popped_value = dq_pkg::DataW'(front_q);
                head_d           = idx_inc(head_q);
                count_d          = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  front_d = '0;
                  back_d  = '0;
                end else if (count_q == CW'(2)) begin
                  front_d = back_q;
                end else begin
                  ram_re        = 1'b1;
                  ram_raddr     = idx_inc(head_q);
                  fetch_front_d = 1'b1;
                  state_d       = ST_FETCH;
                end
              end
            end
            dq_pkg::ACT_POP_BACK: begin
              if (count_q != '0) begin
                res.pop_valid    = 1'b1;
                res.popped_value = dq_pkg::DataW'(back_q);
                tail_d           = idx_dec(tail_q);
                count_d          = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  front_d = '0;
                  back_d  = '0;
                end else if (count_q == CW'(2)) begin
                  back_d = front_q;
                end else begin
                  ram_re        = 1'b1;
                  ram_raddr     = idx_dec(idx_dec(tail_q));
                  fetch_front_d = 1'b0;
                  state_d       = ST_FETCH;
                end
              end
            end
            default: ;
          endcase
          res.element_count = dq_pkg::CountW'(count_d);
          res.is_empty      = (count_d == '0);
          res.front_value   = dq_pkg::DataW'(front_d);
          res.back_value    = dq_pkg::DataW'(back_d);
          out_d             = res;
          // a fetch leaves the result parked until the new end value arrives
          out_valid_d       = (state_d == ST_IDLE);
        end
      end
      ST_FETCH: begin
        if (fetch_front_q) begin
          front_d           = ram_rdata;
          out_d.front_value = dq_pkg::DataW'(ram_rdata);
        end else begin
          back_d           = ram_rdata;
          out_d.back_value = dq_pkg::DataW'(ram_rdata);
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      front_q       <= '0;
      back_q        <= '0;
      fetch_front_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      front_q       <= front_d;
      back_q        <= back_d;
      fetch_front_q <= fetch_front_d;
      out_valid_q   <= out_valid_d;
      out_q         <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // expected tail position from head and count
  logic [CW:0] tail_sum;
  logic [AW-1:0] tail_exp;
  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
  assign tail_exp = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("element count above queue depth");

  a_tail_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q == tail_exp)
    else $error("tail index out of step with head and count");

  a_fetch_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> !out_valid_q)
    else $error("result register busy during fetch");

  a_fetch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |=> out_valid_q && state_q == ST_IDLE)
    else $error("fetch did not complete in one cycle");

endmodule

/* design/dq_ram.sv */
// dq_ram: generic simple dual-port RAM, one write and one read port.
// Read data is registered. No package dependency.
module dq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
